@@ src/bmp_pkg.sv @@
package bmp_pkg;

  localparam int unsigned CNT_W = 10;
  localparam int unsigned VAL_W = 30;

  localparam logic [VAL_W-1:0] P_MOD = 30'd998244353;
  localparam logic [31:0] P_MOD_X1 = 32'd998244353;
  localparam logic [31:0] P_MOD_X2 = 32'd1996488706;
  localparam longint unsigned P_MOD_L = 64'd998244353;
  localparam longint unsigned BARRETT_MU_L = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] BARRETT_MU = BARRETT_MU_L[30:0];

  function automatic longint unsigned mod_pow(longint unsigned base_in,
                                              longint unsigned expo_in);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned e;
    acc = 64'd1;
    b = base_in % P_MOD_L;
    e = expo_in;
    while (e > 0) begin
      if (e[0]) acc = (acc * b) % P_MOD_L;
      b = (b * b) % P_MOD_L;
      e = e >> 1;
    end
    return acc;
  endfunction

endpackage

@@ src/binomial_mod_prime.sv @@
// channel   ports                                     transfer when
// input     in_total_count, in_chosen_count           start && !busy
// result    out_binomial_value, out_result_valid      out_strobe (one cycle)
//
// One item per cycle; each result passes through the queue stage, table read,
// two four-stage Barrett multipliers and output register before it reaches the ports.
// rst_n is synchronous; it empties the queue and all pipeline valid bits.
// The result side cannot stall, so busy stays low in normal operation.
module binomial_mod_prime #(
  parameter int unsigned MAX_N = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [bmp_pkg::CNT_W-1:0] in_total_count,
  input  logic [bmp_pkg::CNT_W-1:0] in_chosen_count,
  output logic                      out_strobe,
  output logic [bmp_pkg::VAL_W-1:0] out_binomial_value,
  output logic                      out_result_valid
);
  import bmp_pkg::*;

  localparam int unsigned AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic [3*AW:0]    f_item, q_item;
  logic             q_empty, q_full;
  logic             push;
  logic             b_v;
  logic [VAL_W-1:0] b_val;
  logic             b_ok;
  logic             strobe_r;
  logic [VAL_W-1:0] val_r;
  logic             ok_r;

  assign busy = q_full;
  assign push = start && !q_full;

  bmp_front #(.MAX_N(MAX_N), .AW(AW)) u_front (
    .total_count (in_total_count),
    .chosen_count(in_chosen_count),
    .item        (f_item)
  );

  bmp_fifo #(.W(3*AW + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(f_item),
    .pop      (!q_empty),
    .pop_data (q_item),
    .empty    (q_empty),
    .full     (q_full)
  );

  bmp_back #(.MAX_N(MAX_N), .AW(AW)) u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .in_v (!q_empty),
    .item (q_item),
    .out_v(b_v),
    .value(b_val),
    .ok   (b_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= b_val;
    ok_r  <= b_ok;
  end

  assign out_strobe         = strobe_r;
  assign out_binomial_value = val_r;
  assign out_result_valid   = ok_r;

`ifndef ASSERT_OFF
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled up");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result_valid |-> out_binomial_value == '0)
    else $error("invalid result carries a value");
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_binomial_value < P_MOD)
    else $error("result not reduced");
`endif
endmodule

@@ src/bmp_fifo.sv @@
module bmp_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

@@ src/bmp_front.sv @@
module bmp_front #(
  parameter int unsigned MAX_N = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic [bmp_pkg::CNT_W-1:0] total_count,
  input  logic [bmp_pkg::CNT_W-1:0] chosen_count,
  output logic [3*AW:0]             item
);
  import bmp_pkg::*;

  logic [CNT_W-1:0]    diff;
  logic                ok;
  logic [AW+CNT_W-1:0] n_ext, d_ext, k_ext;

  always_comb begin
    diff  = total_count - chosen_count;
    ok    = (chosen_count <= total_count) && ({22'd0, total_count} < 32'(MAX_N));
    n_ext = {{AW{1'b0}}, total_count};
    d_ext = {{AW{1'b0}}, diff};
    k_ext = {{AW{1'b0}}, chosen_count};
    item  = {ok, n_ext[AW-1:0], d_ext[AW-1:0], k_ext[AW-1:0]};
  end
endmodule

@@ src/bmp_modmul.sv @@
module bmp_modmul #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  logic [bmp_pkg::VAL_W-1:0] a,
  input  logic [bmp_pkg::VAL_W-1:0] b,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_v,
  output logic [bmp_pkg::VAL_W-1:0] prod,
  output logic [TAG_W-1:0]          out_tag
);
  import bmp_pkg::*;

  logic [3:0]       v_r;
  logic [TAG_W-1:0] tag1_r, tag2_r, tag3_r, tag4_r;
  logic [59:0]      p1_r;
  logic [61:0]      t2_r;
  logic [31:0]      lo2_r, lo3_r, qp3_r;
  logic [31:0]      r_diff;
  logic [VAL_W-1:0] res_nxt, res_r;
  logic [60:0]      qp_full;

  always_comb begin
    qp_full = t2_r[61:31] * P_MOD;
    r_diff  = lo3_r - qp3_r;
    if (r_diff >= P_MOD_X2) begin
      res_nxt = VAL_W'(r_diff - P_MOD_X2);
    end else if (r_diff >= P_MOD_X1) begin
      res_nxt = VAL_W'(r_diff - P_MOD_X1);
    end else begin
      res_nxt = r_diff[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= a * b;
    tag1_r <= in_tag;
    t2_r   <= p1_r[59:29] * BARRETT_MU;
    lo2_r  <= p1_r[31:0];
    tag2_r <= tag1_r;
    qp3_r  <= qp_full[31:0];
    lo3_r  <= lo2_r;
    tag3_r <= tag2_r;
    res_r  <= res_nxt;
    tag4_r <= tag3_r;
  end

  assign out_v   = v_r[3];
  assign prod    = res_r;
  assign out_tag = tag4_r;
endmodule

@@ src/bmp_back.sv @@
module bmp_back #(
  parameter int unsigned MAX_N = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  logic [3*AW:0]             item,
  output logic                      out_v,
  output logic [bmp_pkg::VAL_W-1:0] value,
  output logic                      ok
);
  import bmp_pkg::*;

  typedef logic [VAL_W-1:0] rom_t [MAX_N];

  function automatic rom_t fact_fill();
    rom_t f;
    longint unsigned run;
    run = 64'd1;
    f[0] = 30'd1;
    for (int i = 1; i < MAX_N; i++) begin
      run = (run * longint'(i)) % P_MOD_L;
      f[i] = run[VAL_W-1:0];
    end
    return f;
  endfunction

  function automatic rom_t inv_fill();
    rom_t f;
    rom_t g;
    longint unsigned run;
    f = fact_fill();
    run = mod_pow(longint'(f[MAX_N-1]), P_MOD_L - 64'd2);
    g[MAX_N-1] = run[VAL_W-1:0];
    for (int i = MAX_N - 1; i > 0; i--) begin
      run = (run * longint'(i)) % P_MOD_L;
      g[i-1] = run[VAL_W-1:0];
    end
    return g;
  endfunction

  localparam rom_t FACT_ROM = fact_fill();
  localparam rom_t INV_ROM  = inv_fill();

  logic [AW-1:0]    n_idx, d_idx, k_idx;
  logic             rd_v_r;
  logic [VAL_W-1:0] fn_r, id_r, ik_r;
  logic             ok_r;
  logic             a_v;
  logic [VAL_W-1:0] a_prod;
  logic [VAL_W:0]   a_tag;
  logic             b_v;
  logic [VAL_W-1:0] b_prod;
  logic             b_tag;

  assign n_idx = item[3*AW-1:2*AW];
  assign d_idx = item[2*AW-1:AW];
  assign k_idx = item[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    fn_r <= FACT_ROM[n_idx];
    id_r <= INV_ROM[d_idx];
    ik_r <= INV_ROM[k_idx];
    ok_r <= item[3*AW];
  end

  bmp_modmul #(.TAG_W(VAL_W + 1)) u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (rd_v_r),
    .a      (fn_r),
    .b      (id_r),
    .in_tag ({ok_r, ik_r}),
    .out_v  (a_v),
    .prod   (a_prod),
    .out_tag(a_tag)
  );

  bmp_modmul #(.TAG_W(1)) u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (a_v),
    .a      (a_prod),
    .b      (a_tag[VAL_W-1:0]),
    .in_tag (a_tag[VAL_W]),
    .out_v  (b_v),
    .prod   (b_prod),
    .out_tag(b_tag)
  );

  assign out_v = b_v;
  assign ok    = b_tag;
  assign value = b_tag ? b_prod : '0;
endmodule
